### sv/rbe_pkg.sv
// Shared types and constants for the box entry point pipeline.
// No dependencies.
package rbe_pkg;

    localparam int CW          = 32;          // coordinate width
    localparam int QW          = 48;          // quotient / scaled numerator width
    localparam int DIV_BITS    = 2;           // quotient bits per divider stage
    localparam int DIV_STAGES  = QW / DIV_BITS;
    localparam int HW          = QW / 2;      // split point of t for the products
    localparam int PW          = HW + CW;     // partial product width
    localparam int OW          = 35;          // clamped offset magnitude width
    localparam int PTW         = 37;          // unsaturated point width
    localparam int DW          = 31;          // distance width
    localparam logic [DW-1:0] DIST_MAX = '1;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] s;
        coord_t [2:0] d;
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } raw_t;

    typedef struct packed {
        coord_t [2:0]      s;
        logic   [2:0]      dneg;
        logic   [2:0][CW-1:0] adir;
        coord_t [2:0]      lo;
        coord_t [2:0]      hi;
        coord_t [2:0]      plane;
        logic   [2:0]      cand;
        logic              in_box;
        logic              away;
    } ctx_t;

endpackage

### sv/rbe_chan_if.sv
// Valid/ready channel interfaces for query beats and result beats.
// Depends on rbe_pkg.
interface rbe_in_if;
    logic               valid;
    logic               ready;
    rbe_pkg::coord_t    start_x;
    rbe_pkg::coord_t    start_y;
    rbe_pkg::coord_t    start_z;
    rbe_pkg::coord_t    dir_x;
    rbe_pkg::coord_t    dir_y;
    rbe_pkg::coord_t    dir_z;
    rbe_pkg::coord_t    box_min_x;
    rbe_pkg::coord_t    box_max_x;
    rbe_pkg::coord_t    box_min_y;
    rbe_pkg::coord_t    box_max_y;
    rbe_pkg::coord_t    box_min_z;
    rbe_pkg::coord_t    box_max_z;

    modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                    box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z,
                  output ready);
endinterface

interface rbe_out_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic                        started_inside;
    logic [rbe_pkg::DW-1:0]      distance;
    rbe_pkg::coord_t             point_x;
    rbe_pkg::coord_t             point_y;
    rbe_pkg::coord_t             point_z;

    modport source (output valid, hit, started_inside, distance, point_x, point_y, point_z,
                    input ready);
    modport sink (input valid, hit, started_inside, distance, point_x, point_y, point_z,
                  output ready);
endinterface

### sv/ray_box_entry_point.sv
// Top level: entry point of a ray into an axis-aligned box, Q16.16.
// Depends on rbe_pkg, rbe_chan_if, rbe_div_pipe, rbe_offset.
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | start_x/y/z, dir_x/y/z, box_min/max_x/y/z
//  out_ch   | out | hit, started_inside, distance, point_x/y/z
//
// One beat per cycle while the output is not stalled; stages: input register, setup,
// 24 divider stages (2 quotient bits each), 2 product stages, output register.
// rst_n (async, low) clears only the valid bits; data registers carry no reset.
// The whole pipe holds only when a beat sits in the last product stage while
// the output register is full and not taken; bubbles drain into a waiting output.
module ray_box_entry_point
(
    input  logic       clk,
    input  logic       rst_n,
    rbe_in_if.sink     in_ch,
    rbe_out_if.source  out_ch
);

    localparam int NS = rbe_pkg::DIV_STAGES;

    logic en;

    // valid bits
    logic          v_in_reg;
    logic          v_a_reg;
    logic [NS-1:0] v_div_reg;
    logic          v_m1_reg;
    logic          v_m2_reg;
    logic          out_valid_reg;

    // payload
    rbe_pkg::raw_t                raw_reg;
    rbe_pkg::ctx_t                ctx_a_reg;
    rbe_pkg::ctx_t                ctx_a_next;
    logic [2:0][rbe_pkg::QW-1:0]  num_a_reg;
    logic [2:0][rbe_pkg::QW-1:0]  num_a_next;
    rbe_pkg::ctx_t                ctx_div_reg [NS];
    rbe_pkg::ctx_t                ctx_m1_reg;
    rbe_pkg::ctx_t                ctx_m2_reg;
    logic [rbe_pkg::QW-1:0]       quo [3];
    logic [rbe_pkg::QW-1:0]       t_m1_reg [3];
    logic [rbe_pkg::QW-1:0]       t_m2_reg [3];
    logic signed [rbe_pkg::PTW-1:0] p_m2 [3][3];

    logic                   hit_reg, hit_next;
    logic                   inside_reg, inside_next;
    logic [rbe_pkg::DW-1:0] dist_reg, dist_next;
    rbe_pkg::coord_t [2:0]  point_reg, point_next;

    // a beat only stalls if it would overrun a waiting result
    assign en          = !(v_m2_reg && out_valid_reg && !out_ch.ready);
    assign in_ch.ready = en;

    // ---------------- valid line ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg  <= 1'b0;
            v_a_reg   <= 1'b0;
            v_div_reg <= '0;
            v_m1_reg  <= 1'b0;
            v_m2_reg  <= 1'b0;
        end
        else if (en)
        begin
            v_in_reg  <= in_ch.valid;
            v_a_reg   <= v_in_reg;
            v_div_reg <= {v_div_reg[NS-2:0], v_a_reg};
            v_m1_reg  <= v_div_reg[NS-1];
            v_m2_reg  <= v_m1_reg;
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            raw_reg.s  <= {in_ch.start_z, in_ch.start_y, in_ch.start_x};
            raw_reg.d  <= {in_ch.dir_z, in_ch.dir_y, in_ch.dir_x};
            raw_reg.lo <= {in_ch.box_min_z, in_ch.box_min_y, in_ch.box_min_x};
            raw_reg.hi <= {in_ch.box_max_z, in_ch.box_max_y, in_ch.box_max_x};
        end
    end

    // ---------------- setup: slab tests, face pick, divider operands ----------------
    always_comb
    begin
        logic                        le, ge;
        logic signed [rbe_pkg::CW:0] diff;
        logic signed [rbe_pkg::CW:0] ndiff;
        logic [rbe_pkg::CW-1:0]      dmag;
        ctx_a_next        = '0;
        ctx_a_next.in_box = 1'b1;
        ctx_a_next.away   = 1'b0;
        num_a_next        = '0;
        for (int a = 0; a < 3; a++)
        begin
            le = ($signed(raw_reg.s[a]) <= $signed(raw_reg.lo[a]));
            ge = ($signed(raw_reg.s[a]) >= $signed(raw_reg.hi[a]));
            if ($signed(raw_reg.s[a]) < $signed(raw_reg.lo[a]) ||
                $signed(raw_reg.s[a]) > $signed(raw_reg.hi[a]))
                ctx_a_next.in_box = 1'b0;
            if ((le && $signed(raw_reg.d[a]) <= 0) || (ge && $signed(raw_reg.d[a]) >= 0))
                ctx_a_next.away = 1'b1;
            ctx_a_next.s[a]     = raw_reg.s[a];
            ctx_a_next.lo[a]    = raw_reg.lo[a];
            ctx_a_next.hi[a]    = raw_reg.hi[a];
            ctx_a_next.dneg[a]  = raw_reg.d[a][rbe_pkg::CW-1];
            ctx_a_next.adir[a]  = raw_reg.d[a][rbe_pkg::CW-1] ? (~raw_reg.d[a] + 1'b1)
                                                              : raw_reg.d[a];
            ctx_a_next.plane[a] = le ? raw_reg.lo[a] : raw_reg.hi[a];
            ctx_a_next.cand[a]  = (le || ge) && (raw_reg.d[a] != '0);
            diff = $signed({ctx_a_next.plane[a][rbe_pkg::CW-1], ctx_a_next.plane[a]})
                 - $signed({raw_reg.s[a][rbe_pkg::CW-1], raw_reg.s[a]});
            ndiff = -diff;
            dmag = diff[rbe_pkg::CW] ? ndiff[rbe_pkg::CW-1:0] : diff[rbe_pkg::CW-1:0];
            num_a_next[a] = {dmag, 16'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_a_reg <= ctx_a_next;
            num_a_reg <= num_a_next;
        end
    end

    // ---------------- divider lanes, context travels alongside ----------------
    for (genvar a = 0; a < 3; a++) begin : g_div
        rbe_div_pipe u_div
        (
            .clk (clk),
            .en  (en),
            .num (num_a_reg[a]),
            .den (ctx_a_reg.adir[a]),
            .quo (quo[a])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_div_reg[0] <= ctx_a_reg;
            for (int k = 1; k < NS; k++)
                ctx_div_reg[k] <= ctx_div_reg[k-1];
            ctx_m1_reg <= ctx_div_reg[NS-1];
            ctx_m2_reg <= ctx_m1_reg;
            for (int a = 0; a < 3; a++)
            begin
                t_m1_reg[a] <= quo[a];
                t_m2_reg[a] <= t_m1_reg[a];
            end
        end
    end

    // ---------------- hit point on the other two axes of each face ----------------
    for (genvar a = 0; a < 3; a++) begin : g_face
        for (genvar o = 0; o < 3; o++) begin : g_axis
            if (o != a) begin : g_lane
                rbe_offset u_off
                (
                    .clk  (clk),
                    .en   (en),
                    .t    (quo[a]),
                    .adir (ctx_div_reg[NS-1].adir[o]),
                    .neg  (ctx_div_reg[NS-1].dneg[o]),
                    .s    (ctx_div_reg[NS-1].s[o]),
                    .p    (p_m2[a][o])
                );
            end else begin : g_plane
                assign p_m2[a][o] = '0;
            end
        end
    end

    // ---------------- face rectangle test and first-face pick ----------------
    always_comb
    begin
        logic [2:0] ok;
        logic       found;
        for (int a = 0; a < 3; a++)
        begin
            ok[a] = ctx_m2_reg.cand[a];
            for (int o = 0; o < 3; o++)
            begin
                if (o != a)
                begin
                    if (p_m2[a][o] < $signed({{(rbe_pkg::PTW-rbe_pkg::CW){ctx_m2_reg.lo[o][31]}},
                                              ctx_m2_reg.lo[o]}) ||
                        p_m2[a][o] > $signed({{(rbe_pkg::PTW-rbe_pkg::CW){ctx_m2_reg.hi[o][31]}},
                                              ctx_m2_reg.hi[o]}))
                        ok[a] = 1'b0;
                end
            end
        end
        hit_next    = 1'b0;
        inside_next = ctx_m2_reg.in_box;
        dist_next   = '0;
        point_next  = '0;
        found       = 1'b0;
        if (ctx_m2_reg.in_box)
        begin
            hit_next   = 1'b1;
            point_next = ctx_m2_reg.s;
        end
        else if (!ctx_m2_reg.away)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (ok[a] && !found)
                begin
                    found     = 1'b1;
                    hit_next  = 1'b1;
                    dist_next = (|t_m2_reg[a][rbe_pkg::QW-1:rbe_pkg::DW]) ? rbe_pkg::DIST_MAX
                                                                       : t_m2_reg[a][rbe_pkg::DW-1:0];
                    for (int o = 0; o < 3; o++)
                        point_next[o] = (o == a) ? ctx_m2_reg.plane[o]
                                                 : p_m2[a][o][rbe_pkg::CW-1:0];
                end
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ch.ready)
            out_valid_reg <= v_m2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ch.ready)
        begin
            hit_reg    <= hit_next;
            inside_reg <= inside_next;
            dist_reg   <= dist_next;
            point_reg  <= point_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.hit            = hit_reg;
    assign out_ch.started_inside = inside_reg;
    assign out_ch.distance       = dist_reg;
    assign out_ch.point_x        = point_reg[0];
    assign out_ch.point_y        = point_reg[1];
    assign out_ch.point_z        = point_reg[2];

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.hit |-> out_ch.distance == '0 && out_ch.point_x == '0 &&
                                        out_ch.point_y == '0 && out_ch.point_z == '0)
        else $error("miss beat carries nonzero payload");
    a_inside_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.started_inside |-> out_ch.hit && out_ch.distance == '0)
        else $error("inside start without zero-distance hit");
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid && !out_ch.ready && v_m2_reg)
        else $error("input held off without a blocked result");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        v_m2_reg && out_valid_reg && !out_ch.ready |=> v_m2_reg && out_valid_reg)
        else $error("result lost under stall");
`endif

endmodule

### sv/rbe_div_pipe.sv
// Pipelined restoring divider, QW-bit numerator by CW-bit divisor, DIV_BITS per stage.
// Depends on rbe_pkg.
module rbe_div_pipe
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [rbe_pkg::QW-1:0]    num,
    input  logic [rbe_pkg::CW-1:0]    den,
    output logic [rbe_pkg::QW-1:0]    quo
);

    logic [rbe_pkg::CW-1:0] rem_reg [rbe_pkg::DIV_STAGES];
    logic [rbe_pkg::QW-1:0] num_reg [rbe_pkg::DIV_STAGES];
    logic [rbe_pkg::QW-1:0] quo_reg [rbe_pkg::DIV_STAGES];
    logic [rbe_pkg::CW-1:0] den_reg [rbe_pkg::DIV_STAGES];

    for (genvar k = 0; k < rbe_pkg::DIV_STAGES; k++) begin : g_stage
        logic [rbe_pkg::CW-1:0] r_in;
        logic [rbe_pkg::QW-1:0] n_in;
        logic [rbe_pkg::QW-1:0] q_in;
        logic [rbe_pkg::CW-1:0] d_in;
        logic [rbe_pkg::CW-1:0] rem_next;
        logic [rbe_pkg::QW-1:0] num_next;
        logic [rbe_pkg::QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign n_in = num;
            assign q_in = '0;
            assign d_in = den;
        end else begin : g_next
            assign r_in = rem_reg[k-1];
            assign n_in = num_reg[k-1];
            assign q_in = quo_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        always_comb
        begin
            logic [rbe_pkg::CW:0] trial;
            rem_next = r_in;
            num_next = n_in;
            quo_next = q_in;
            for (int j = 0; j < rbe_pkg::DIV_BITS; j++)
            begin
                trial    = {rem_next, num_next[rbe_pkg::QW-1]};
                num_next = {num_next[rbe_pkg::QW-2:0], 1'b0};
                if (trial >= {1'b0, d_in})
                begin
                    trial    = trial - {1'b0, d_in};
                    quo_next = {quo_next[rbe_pkg::QW-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[rbe_pkg::QW-2:0], 1'b0};
                end
                rem_next = trial[rbe_pkg::CW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= d_in;
            end
        end
    end

    assign quo = quo_reg[rbe_pkg::DIV_STAGES-1];

endmodule

### sv/rbe_offset.sv
// Two-stage lane: start + trunc(t * dir / 2^16), magnitude clamped past any box.
// Depends on rbe_pkg.
module rbe_offset
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [rbe_pkg::QW-1:0]        t,
    input  logic [rbe_pkg::CW-1:0]        adir,
    input  logic                          neg,
    input  rbe_pkg::coord_t               s,
    output logic signed [rbe_pkg::PTW-1:0] p
);

    logic [rbe_pkg::PW-1:0]         ph_reg;
    logic [rbe_pkg::PW-1:0]         pl_reg;
    logic                           neg_reg;
    rbe_pkg::coord_t                s_reg;
    logic signed [rbe_pkg::PTW-1:0] p_reg;
    logic signed [rbe_pkg::PTW-1:0] p_next;

    // stage 1: two 24x32 partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg  <= t[rbe_pkg::QW-1:rbe_pkg::HW] * adir;
            pl_reg  <= t[rbe_pkg::HW-1:0] * adir;
            neg_reg <= neg;
            s_reg   <= s;
        end
    end

    // stage 2: sum, scale, clamp at 2^34, sign and add
    always_comb
    begin
        logic [rbe_pkg::PW+rbe_pkg::HW-1:0] full;
        logic [rbe_pkg::OW-1:0]             mag;
        logic signed [rbe_pkg::OW:0]        off;
        full = ({{rbe_pkg::HW{1'b0}}, ph_reg} << rbe_pkg::HW) + {{rbe_pkg::HW{1'b0}}, pl_reg};
        if (|full[rbe_pkg::PW+rbe_pkg::HW-1:rbe_pkg::OW+15])
            mag = {1'b1, {(rbe_pkg::OW-1){1'b0}}};
        else
            mag = {1'b0, full[rbe_pkg::OW+14:16]};
        off    = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        p_next = $signed({{(rbe_pkg::PTW-rbe_pkg::CW){s_reg[rbe_pkg::CW-1]}}, s_reg})
               + $signed({off[rbe_pkg::OW], off});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

### test/ray_box_entry_point_tb.sv
// Testbench for ray_box_entry_point: directed and random box entry queries.
// Depends on rbe_pkg, rbe_chan_if and the block; predicts each result in SV.
module ray_box_entry_point_tb;

    typedef rbe_pkg::coord_t coord_t;
    localparam int DW = rbe_pkg::DW;

    typedef struct {
        logic signed [63:0] s[3];
        logic signed [63:0] d[3];
        logic signed [63:0] lo[3];
        logic signed [63:0] hi[3];
    } query_t;

    typedef struct packed {
        logic          hit;
        logic          started_inside;
        logic [DW-1:0] distance;
        coord_t        px;
        coord_t        py;
        coord_t        pz;
    } entry_t;

    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;

    rbe_in_if  in_ch();
    rbe_out_if out_ch();

    ray_box_entry_point u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    entry_t entry_q[$];
    int     errors;
    int     cycles;
    int     send_idle_pct;   // sender gap chance, percent
    int     recv_stall_pct;  // receiver stall chance, percent
    logic   hold_on = 1'b0;  // forced receiver stall in progress
    event   hold_go;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Magnitude of a signed 64-bit value.
    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // trunc(t * d / 2^16), magnitude clamped to 2^40.
    function automatic logic signed [63:0] scaled_offset(logic [63:0] t,
                                                          logic signed [63:0] d);
        logic [63:0] ad;
        logic [63:0] th;
        logic [63:0] tl;
        logic [63:0] hp;
        logic [63:0] m;
        ad = abs64(d);
        th = t >> 24;
        tl = t & 64'hFF_FFFF;
        hp = th * ad;
        if (hp >= (64'd1 << 39))
            m = 64'd1 << 40;
        else
        begin
            m = ((hp << 24) + tl * ad) >> 16;
            if (m > (64'd1 << 40))
                m = 64'd1 << 40;
        end
        return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic coord_t sat_coord(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Intersect one face plane; returns 1 when its rectangle holds the point.
    function automatic bit face_hit(query_t q, int a, logic signed [63:0] plane,
                                    output logic [63:0] t,
                                    output logic signed [63:0] p[3]);
        t = 0;
        for (int o = 0; o < 3; o++)
            p[o] = 0;
        if (q.d[a] == 0)
            return 0;
        t = (abs64(plane - q.s[a]) << 16) / abs64(q.d[a]);
        for (int o = 0; o < 3; o++)
        begin
            if (o == a)
                p[o] = plane;
            else
            begin
                p[o] = q.s[o] + scaled_offset(t, q.d[o]);
                if (p[o] < q.lo[o] || p[o] > q.hi[o])
                    return 0;
            end
        end
        return 1;
    endfunction

    function automatic entry_t predict_entry(query_t q);
        entry_t r;
        logic signed [63:0] p[3];
        logic [63:0] t;
        logic [63:0] dist_v;
        bit in_box;
        bit away;
        bit found;
        in_box = 1;
        away = 0;
        found = 0;
        dist_v = 0;
        for (int a = 0; a < 3; a++)
        begin
            p[a] = 0;
            if (q.s[a] < q.lo[a] || q.s[a] > q.hi[a])
                in_box = 0;
        end
        if (in_box)
        begin
            found = 1;
            for (int a = 0; a < 3; a++)
                p[a] = q.s[a];
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (q.s[a] <= q.lo[a] && q.d[a] <= 0)
                    away = 1;
                if (q.s[a] >= q.hi[a] && q.d[a] >= 0)
                    away = 1;
            end
            for (int a = 0; a < 3 && !away && !found; a++)
            begin
                if (q.s[a] <= q.lo[a] && face_hit(q, a, q.lo[a], t, p))
                    found = 1;
                else if (q.s[a] >= q.hi[a] && face_hit(q, a, q.hi[a], t, p))
                    found = 1;
                if (found)
                    dist_v = t;
            end
        end
        if (!found)
        begin
            dist_v = 0;
            for (int a = 0; a < 3; a++)
                p[a] = 0;
        end
        if (dist_v > 64'h7FFF_FFFF)
            dist_v = 64'h7FFF_FFFF;
        r.hit = found;
        r.started_inside = in_box;
        r.distance = dist_v[DW-1:0];
        r.px = sat_coord(p[0]);
        r.py = sat_coord(p[1]);
        r.pz = sat_coord(p[2]);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    // Send one beat; the sender may idle first, then holds valid until taken.
    // Valid stays high on return so a following beat goes out back to back.
    task automatic send_query(query_t q);
        if (($urandom % 100) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (($urandom % 100) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.start_x   <= q.s[0][31:0];
        in_ch.start_y   <= q.s[1][31:0];
        in_ch.start_z   <= q.s[2][31:0];
        in_ch.dir_x     <= q.d[0][31:0];
        in_ch.dir_y     <= q.d[1][31:0];
        in_ch.dir_z     <= q.d[2][31:0];
        in_ch.box_min_x <= q.lo[0][31:0];
        in_ch.box_max_x <= q.hi[0][31:0];
        in_ch.box_min_y <= q.lo[1][31:0];
        in_ch.box_max_y <= q.hi[1][31:0];
        in_ch.box_min_z <= q.lo[2][31:0];
        in_ch.box_max_z <= q.hi[2][31:0];
        entry_q.push_back(predict_entry(q));
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    function automatic query_t make_query(coord_t sx, coord_t sy, coord_t sz,
                                          coord_t dx, coord_t dy, coord_t dz,
                                          coord_t lx, coord_t hx, coord_t ly,
                                          coord_t hy, coord_t lz, coord_t hz);
        query_t q;
        q.s[0] = sx;  q.s[1] = sy;  q.s[2] = sz;
        q.d[0] = dx;  q.d[1] = dy;  q.d[2] = dz;
        q.lo[0] = lx; q.hi[0] = hx;
        q.lo[1] = ly; q.hi[1] = hy;
        q.lo[2] = lz; q.hi[2] = hz;
        return q;
    endfunction

    // Coordinate biased toward small values and the extremes.
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 3) == 0 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return 0;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        coord_t a;
        coord_t b;
        for (int i = 0; i < 3; i++)
        begin
            a = rand_coord();
            b = rand_coord();
            // mostly well-formed boxes; some inverted
            if ($urandom_range(0, 9) != 0 && a > b)
            begin
                q.lo[i] = b;
                q.hi[i] = a;
            end
            else
            begin
                q.lo[i] = a;
                q.hi[i] = b;
            end
            q.s[i] = rand_coord();
            q.d[i] = $urandom_range(0, 7) == 0 ? 0 : rand_coord();
        end
        // often aim at the box center so that faces are really hit
        if ($urandom_range(0, 1))
            for (int i = 0; i < 3; i++)
                q.d[i] = ((q.lo[i] + q.hi[i]) >>> 1) - q.s[i] + $signed($urandom_range(0, 15)) - 8;
        for (int i = 0; i < 3; i++)
            q.d[i] = $signed(q.d[i][31:0]);
        return q;
    endfunction

    // Forced receiver hold-off, counted here.
    initial
    begin
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (200) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Result checker: random stall, plus any forced hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (entry_q.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    entry_t w;
                    w = entry_q.pop_front();
                    if (out_ch.hit !== w.hit)
                        report_mismatch("hit", out_ch.hit, w.hit);
                    if (out_ch.started_inside !== w.started_inside)
                        report_mismatch("started_inside", out_ch.started_inside,
                                        w.started_inside);
                    if (out_ch.distance !== w.distance)
                        report_mismatch("distance", out_ch.distance, w.distance);
                    if (out_ch.point_x !== w.px)
                        report_mismatch("point_x", out_ch.point_x, w.px);
                    if (out_ch.point_y !== w.py)
                        report_mismatch("point_y", out_ch.point_y, w.py);
                    if (out_ch.point_z !== w.pz)
                        report_mismatch("point_z", out_ch.point_z, w.pz);
                end
            end
            if (hold_on)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom % 100) >= recv_stall_pct;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (entry_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        coord_t mx;
        coord_t mn;
        coord_t one;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        one = 32'sh0001_0000;
        // start inside, and start exactly on a corner
        send_query(make_query(0, 0, 0, one, 0, 0, -one, one, -one, one, -one, one));
        send_query(make_query(one, one, one, 0, 0, 0, -one, one, -one, one, -one, one));
        // each face from outside
        send_query(make_query(-4*one, 0, 0, one, 0, 0, -one, one, -one, one, -one, one));
        send_query(make_query(4*one, 0, 0, -one, 0, 0, -one, one, -one, one, -one, one));
        send_query(make_query(0, -4*one, 0, 0, one, 0, -one, one, -one, one, -one, one));
        send_query(make_query(0, 4*one, 0, 0, -one, 0, -one, one, -one, one, -one, one));
        send_query(make_query(0, 0, -4*one, 0, 0, one, -one, one, -one, one, -one, one));
        send_query(make_query(0, 0, 4*one, 0, 0, -one, -one, one, -one, one, -one, one));
        // pointing away, and zero direction on the face axis
        send_query(make_query(-4*one, 0, 0, -one, 0, 0, -one, one, -one, one, -one, one));
        send_query(make_query(-4*one, 0, 0, 0, one, 0, -one, one, -one, one, -one, one));
        // miss beside a face rectangle, inverted box
        send_query(make_query(-4*one, 3*one, 0, one, 0, 0, -one, one, -one, one, -one, one));
        send_query(make_query(0, 0, 0, one, one, one, one, -one, -one, one, -one, one));
        // extremes: huge distance, tiny direction, saturating point
        send_query(make_query(mn, 0, 0, 1, 0, 0, mx - 1, mx, mn, mx, mn, mx));
        send_query(make_query(mn, mn, mn, mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_query(make_query(mx, mx, mx, mn, mn, mn, mn, mn, mn, mn, mn, mn));
        send_query(make_query(mn, 0, 0, mx, mx, mn, 0, one, mn, mx, mn, mx));
        send_query(make_query(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                              mn, mn, mn, mn, mn, mn));
        send_query(make_query(mn, mn, mn, mn, mn, mn, mx, mx, mx, mx, mx, mx));
        wait_drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_query(rand_query());
    endtask

    // Receiver holds off long enough for the pipe to fill and stall the input.
    task automatic test_backpressure();
        -> hold_go;
        test_random(80);
        wait_drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        {in_ch.start_x, in_ch.start_y, in_ch.start_z} = '0;
        {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z} = '0;
        {in_ch.box_min_x, in_ch.box_max_x, in_ch.box_min_y} = '0;
        {in_ch.box_max_y, in_ch.box_min_z, in_ch.box_max_z} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);                              // full rate
        send_idle_pct = 76;
        test_random(250);
        wait_drain();                                  // sender pauses until drained
        send_idle_pct = 0;
        recv_stall_pct = 76;
        test_random(250);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random(300);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(100);

        wait_drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### sim.f
sv/rbe_pkg.sv
sv/rbe_chan_if.sv
sv/rbe_div_pipe.sv
sv/rbe_offset.sv
sv/ray_box_entry_point.sv
test/ray_box_entry_point_tb.sv
